>>> rtl/core/prs_pkg.sv
// Shared types and constants of the polynomial root scaler.
`default_nettype none

package prs_pkg;

  localparam int MAX_LEN = 1024;
  localparam int INDEX_W = $clog2(MAX_LEN);

  localparam int DATA_W   = 16;
  localparam int FACTOR_W = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_ALPHA_RE = 2'd1,
    CFG_ALPHA_IM = 2'd2
  } cfg_reg_t;

  // Operand pairs for the shared complex multiplier
  typedef enum logic [1:0] {
    MUL_POWER  = 2'd0,
    MUL_RESULT = 2'd1,
    MUL_FACTOR = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     pow_write;
    logic     out_write;
    logic     fac_write;
  } dp_cmd_t;

  typedef struct packed {
    logic pow_more;
    logic pow_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/prs_datapath.sv
// Datapath: configuration registers, complex multiplier, power and factor state, output word.
`default_nettype none

module prs_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  prs_pkg::dp_cmd_t                      cmd,
  output prs_pkg::dp_status_t                   status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [prs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [prs_pkg::DATA_W-1:0]            cfg_data,
  input  logic signed [prs_pkg::DATA_W-1:0]     coef_re,
  input  logic signed [prs_pkg::DATA_W-1:0]     coef_im,
  input  logic signed [prs_pkg::DATA_W-1:0]     item_alpha_re,
  input  logic signed [prs_pkg::DATA_W-1:0]     item_alpha_im,
  input  logic                                  last_coef,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [prs_pkg::DATA_W-1:0]     out_re,
  output logic signed [prs_pkg::DATA_W-1:0]     out_im,
  output logic                                  out_last,
  output logic                                  saturated
);
  import prs_pkg::*;

  localparam int PROD_W = FACTOR_W + DATA_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [FACTOR_W-1:0] ONE_Q30 = FACTOR_W'(1) <<< 30;
  localparam logic [INDEX_W-1:0] INDEX_MAX = INDEX_W'(MAX_LEN - 1);

  localparam logic signed [SUM_W-1:0] HALF_F = SUM_W'(1) <<< 13;
  localparam logic signed [SUM_W-1:0] HALF_R = SUM_W'(1) <<< 29;
  localparam logic signed [SUM_W-1:0] F_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] F_MIN = SUM_W'(-64'sd2147483648);
  localparam logic signed [SUM_W-1:0] R_MAX = SUM_W'(64'sd32767);
  localparam logic signed [SUM_W-1:0] R_MIN = SUM_W'(-64'sd32768);

  // configuration
  logic                       per_coef_mode;
  logic signed [DATA_W-1:0]   alpha_re;
  logic signed [DATA_W-1:0]   alpha_im;

  // latched item
  logic signed [DATA_W-1:0]   item_coef_re;
  logic signed [DATA_W-1:0]   item_coef_im;
  logic signed [DATA_W-1:0]   item_base_re;
  logic signed [DATA_W-1:0]   item_base_im;
  logic                       item_last;

  // running state
  logic [INDEX_W-1:0]         coef_index;
  logic signed [FACTOR_W-1:0] factor_re;
  logic signed [FACTOR_W-1:0] factor_im;
  logic                       chain_clip;
  logic [INDEX_W-1:0]         pow_count;
  logic signed [FACTOR_W-1:0] pow_re;
  logic signed [FACTOR_W-1:0] pow_im;
  logic                       pow_clip;

  // multiplier
  logic signed [FACTOR_W-1:0] op_a_re;
  logic signed [FACTOR_W-1:0] op_a_im;
  logic signed [DATA_W-1:0]   op_b_re;
  logic signed [DATA_W-1:0]   op_b_im;
  logic signed [PROD_W-1:0]   prod_rr;
  logic signed [PROD_W-1:0]   prod_ii;
  logic signed [PROD_W-1:0]   prod_ri;
  logic signed [PROD_W-1:0]   prod_ir;

  logic signed [SUM_W-1:0]    sum_re;
  logic signed [SUM_W-1:0]    sum_im;
  logic signed [SUM_W-1:0]    shf_f_re;
  logic signed [SUM_W-1:0]    shf_f_im;
  logic signed [SUM_W-1:0]    shf_r_re;
  logic signed [SUM_W-1:0]    shf_r_im;
  logic signed [FACTOR_W-1:0] rnd_f_re;
  logic signed [FACTOR_W-1:0] rnd_f_im;
  logic signed [DATA_W-1:0]   rnd_r_re;
  logic signed [DATA_W-1:0]   rnd_r_im;
  logic                       clip_f;
  logic                       clip_r;
  logic                       restart;

  // refuse register writes while reset is applied
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      per_coef_mode <= 1'b0;
      alpha_re      <= 16'sd16384;
      alpha_im      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:     per_coef_mode <= cfg_data[0];
        CFG_ALPHA_RE: alpha_re      <= cfg_data;
        CFG_ALPHA_IM: alpha_im      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_coef_re <= coef_re;
      item_coef_im <= coef_im;
      item_base_re <= item_alpha_re;
      item_base_im <= item_alpha_im;
      item_last    <= last_coef;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_POWER: begin
        op_a_re = pow_re;
        op_a_im = pow_im;
        op_b_re = item_base_re;
        op_b_im = item_base_im;
      end
      MUL_RESULT: begin
        op_a_re = per_coef_mode ? pow_re : factor_re;
        op_a_im = per_coef_mode ? pow_im : factor_im;
        op_b_re = item_coef_re;
        op_b_im = item_coef_im;
      end
      default: begin
        op_a_re = factor_re;
        op_a_im = factor_im;
        op_b_re = alpha_re;
        op_b_im = alpha_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_rr <= PROD_W'(op_a_re) * PROD_W'(op_b_re);
      prod_ii <= PROD_W'(op_a_im) * PROD_W'(op_b_im);
      prod_ri <= PROD_W'(op_a_re) * PROD_W'(op_b_im);
      prod_ir <= PROD_W'(op_a_im) * PROD_W'(op_b_re);
    end
  end

  // round half up, then clip to Q2.30 or Q4.12
  always_comb begin
    sum_re   = SUM_W'(prod_rr) - SUM_W'(prod_ii);
    sum_im   = SUM_W'(prod_ri) + SUM_W'(prod_ir);
    shf_f_re = (sum_re + HALF_F) >>> 14;
    shf_f_im = (sum_im + HALF_F) >>> 14;
    shf_r_re = (sum_re + HALF_R) >>> 30;
    shf_r_im = (sum_im + HALF_R) >>> 30;
    clip_f   = 1'b0;
    clip_r   = 1'b0;

    if (shf_f_re > F_MAX) begin
      rnd_f_re = FACTOR_W'(F_MAX);
      clip_f   = 1'b1;
    end else if (shf_f_re < F_MIN) begin
      rnd_f_re = FACTOR_W'(F_MIN);
      clip_f   = 1'b1;
    end else begin
      rnd_f_re = shf_f_re[FACTOR_W-1:0];
    end
    if (shf_f_im > F_MAX) begin
      rnd_f_im = FACTOR_W'(F_MAX);
      clip_f   = 1'b1;
    end else if (shf_f_im < F_MIN) begin
      rnd_f_im = FACTOR_W'(F_MIN);
      clip_f   = 1'b1;
    end else begin
      rnd_f_im = shf_f_im[FACTOR_W-1:0];
    end

    if (shf_r_re > R_MAX) begin
      rnd_r_re = DATA_W'(R_MAX);
      clip_r   = 1'b1;
    end else if (shf_r_re < R_MIN) begin
      rnd_r_re = DATA_W'(R_MIN);
      clip_r   = 1'b1;
    end else begin
      rnd_r_re = shf_r_re[DATA_W-1:0];
    end
    if (shf_r_im > R_MAX) begin
      rnd_r_im = DATA_W'(R_MAX);
      clip_r   = 1'b1;
    end else if (shf_r_im < R_MIN) begin
      rnd_r_im = DATA_W'(R_MIN);
      clip_r   = 1'b1;
    end else begin
      rnd_r_im = shf_r_im[DATA_W-1:0];
    end
  end

  assign restart = item_last || (coef_index == INDEX_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_index <= '0;
      factor_re  <= ONE_Q30;
      factor_im  <= '0;
      chain_clip <= 1'b0;
      pow_count  <= '0;
      pow_re     <= ONE_Q30;
      pow_im     <= '0;
      pow_clip   <= 1'b0;
    end else if (cmd.fac_write) begin
      // shared factor advances in both modes, or resets on restart; power starts again from one
      if (restart) begin
        coef_index <= '0;
        factor_re  <= ONE_Q30;
        factor_im  <= '0;
        chain_clip <= 1'b0;
      end else begin
        coef_index <= coef_index + 1'b1;
        factor_re  <= rnd_f_re;
        factor_im  <= rnd_f_im;
        chain_clip <= chain_clip | clip_f;
      end
      pow_count <= '0;
      pow_re    <= ONE_Q30;
      pow_im    <= '0;
      pow_clip  <= 1'b0;
    end else if (cmd.pow_write) begin
      pow_count <= pow_count + 1'b1;
      pow_re    <= rnd_f_re;
      pow_im    <= rnd_f_im;
      pow_clip  <= pow_clip | clip_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      out_re    <= rnd_r_re;
      out_im    <= rnd_r_im;
      out_last  <= item_last;
      saturated <= (per_coef_mode ? pow_clip : chain_clip) | clip_r;
    end
  end

  assign status.pow_more = per_coef_mode && (pow_count != coef_index);
  assign status.pow_last = (pow_count + 1'b1) == coef_index;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> rtl/core/prs_ctrl.sv
// Controller: sequences power build, result product and factor update for each word.
`default_nettype none

module prs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  prs_pkg::dp_status_t status,
  output prs_pkg::dp_cmd_t    cmd
);
  import prs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POW_MUL,
    S_POW_ACC,
    S_RES_MUL,
    S_RES_ACC,
    S_FAC_ACC
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load_item = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.mul_sel   = MUL_RESULT;
    cmd.pow_write = 1'b0;
    cmd.out_write = 1'b0;
    cmd.fac_write = 1'b0;
    case (state)
      S_IDLE: begin
        // hold off input words while reset is applied
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_item = 1'b1;
          state_next    = status.pow_more ? S_POW_MUL : S_RES_MUL;
        end
      end
      S_POW_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_POWER;
        state_next  = S_POW_ACC;
      end
      S_POW_ACC: begin
        cmd.pow_write = 1'b1;
        state_next    = status.pow_last ? S_RES_MUL : S_POW_MUL;
      end
      S_RES_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RESULT;
        state_next  = S_RES_ACC;
      end
      S_RES_ACC: begin
        // hold the result products until the output word is free
        if (status.out_free) begin
          cmd.out_write = 1'b1;
          cmd.mul_en    = 1'b1;
          cmd.mul_sel   = MUL_FACTOR;
          state_next    = S_FAC_ACC;
        end
      end
      S_FAC_ACC: begin
        cmd.fac_write = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/polynomial_root_scaler.sv
// Top level of the polynomial root scaler: controller and datapath.
//
//   channel | handshake                | payload
//   --------+--------------------------+----------------------------------------------
//   in      | in_valid / in_ready      | coef_re, coef_im, item_alpha_re/_im, last_coef
//   out     | out_valid / out_ready    | out_re, out_im, out_last, saturated
//   cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Shared mode: each word goes through accept, result multiply, result round and factor round.
// Per-coefficient mode: the coefficient at index k first takes k power steps; each power step
// is a multiply state and a round state through the one complex multiplier.
// Reset is synchronous and holds in_ready and cfg_ready low; the block accepts a word
// as soon as reset is released.
// A result waits in the output register; a stalled output holds the following word at its
// result round, and the next input word is taken while the result is still waiting.
`default_nettype none

module polynomial_root_scaler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [prs_pkg::DATA_W-1:0]     coef_re,
  input  logic signed [prs_pkg::DATA_W-1:0]     coef_im,
  input  logic signed [prs_pkg::DATA_W-1:0]     item_alpha_re,
  input  logic signed [prs_pkg::DATA_W-1:0]     item_alpha_im,
  input  logic                                  last_coef,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [prs_pkg::DATA_W-1:0]     out_re,
  output logic signed [prs_pkg::DATA_W-1:0]     out_im,
  output logic                                  out_last,
  output logic                                  saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [prs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [prs_pkg::DATA_W-1:0]            cfg_data
);
  import prs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  prs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  prs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .coef_re       (coef_re),
    .coef_im       (coef_im),
    .item_alpha_re (item_alpha_re),
    .item_alpha_im (item_alpha_im),
    .last_coef     (last_coef),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_re        (out_re),
    .out_im        (out_im),
    .out_last      (out_last),
    .saturated     (saturated)
  );

endmodule

`default_nettype wire

>>> rtl/core/prs_checker.sv
// Port-level checks of the polynomial root scaler, bound to the top level.
`default_nettype none

module prs_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [prs_pkg::DATA_W-1:0]     out_re,
  input logic signed [prs_pkg::DATA_W-1:0]     out_im,
  input logic                                  out_last,
  input logic                                  saturated
);

  // one word at a time: busy in the cycle after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in two consecutive cycles");

  // a result never appears in the cycle right after its word was taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a new result is posted only while the block is still busy
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result posted while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im)
      && $stable(out_last) && $stable(saturated))
    else $error("stalled output word changed");

endmodule

bind polynomial_root_scaler prs_checker u_prs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_re    (out_re),
  .out_im    (out_im),
  .out_last  (out_last),
  .saturated (saturated)
);

`default_nettype wire
